// ===== src/kfsn_pkg.sv =====
`timescale 1ns / 1ps
package kfsn_pkg;
	localparam int MAX_KEYFRAMES_DEF = 4096;
	localparam int MAX_CHANNELS_DEF  = 4;

	localparam logic [1:0] REG_INTERP = 2'd0;
	localparam logic [1:0] REG_SCALE  = 2'd1;
	localparam logic [1:0] REG_QUAT   = 2'd2;
	localparam logic [1:0] REG_ORDER  = 2'd3;

	localparam logic [1:0] MODE_LINEAR    = 2'd0;
	localparam logic [1:0] MODE_STEP      = 2'd1;
	localparam logic [1:0] MODE_CUBIC     = 2'd2;
	// spare code, behaves as cubic
	localparam logic [1:0] MODE_CUBIC_ALT = 2'd3;

	// which node of a channel is being produced
	typedef enum logic [1:0] {
		NODE_HELD  = 2'd0,
		NODE_LEFT  = 2'd1,
		NODE_RIGHT = 2'd2
	} node_kind_t;

	// divider operand selection
	typedef enum logic [1:0] {
		DIV_LINEAR = 2'd0,
		DIV_LEFT   = 2'd1,
		DIV_RIGHT  = 2'd2
	} div_sel_t;

	// controller -> datapath commands
	typedef struct packed {
		logic       store;      // write element into current arrays
		logic       kf_start;   // compute scaled time, latch keyframe flags
		logic       dot_step;   // accumulate one dot product term
		logic       flip;       // apply sign flip if dot product negative
		logic       div_start;  // start divider
		div_sel_t   div_sel;
		logic       emit;       // load output register
		node_kind_t kind;
		logic [1:0] chan;
		logic       last_node;
		logic       kf_end;     // commit prev state, advance or clear count
	} kfsn_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic div_busy;
		logic out_full;
	} kfsn_sts_t;

	// saturate a signed 64-bit value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

// ===== src/keyframe_to_spline_nodes.sv =====
`timescale 1ns / 1ps
// Element without last_channel: stored, and the next item can be taken next cycle.
// Completing element: time scaling and a closing step (plus the quaternion check),
// then per channel a divide (cut short if the divisor is not positive; two divides in
// cubic mode) and 1-3 node emissions, one a cycle unless stalled or awaiting a divide.
// No new item is taken until the keyframe is done; the shared bit-serial divider sets the pace.
// Reset (arst_n low, asynchronous): registers to defaults, previous values,
// previous time and keyframe count cleared, output empty.
module keyframe_to_spline_nodes #(
	parameter int MAX_KEYFRAMES = kfsn_pkg::MAX_KEYFRAMES_DEF,
	parameter int MAX_CHANNELS  = kfsn_pkg::MAX_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] key_time,
	input  logic [1:0]         channel,
	input  logic signed [31:0] value,
	input  logic signed [31:0] left_tangent,
	input  logic signed [31:0] right_tangent,
	input  logic               last_channel,
	input  logic               last_keyframe,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         out_channel,
	output logic [12:0]        node_index,
	output logic signed [31:0] node_time,
	output logic signed [31:0] node_value,
	output logic signed [31:0] node_slope,
	output logic               overflow,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	logic [1:0]  mode_q;
	logic [30:0] scale_q;
	logic        quat_q, order_q;
	logic        kf_first, kf_last;
	kfsn_pkg::kfsn_cmd_t cmd;
	kfsn_pkg::kfsn_sts_t sts;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			scale_q <= 31'd65536;
			quat_q  <= 1'b0;
			order_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kfsn_pkg::REG_INTERP: mode_q  <= cfg_data[1:0];
				kfsn_pkg::REG_SCALE:  scale_q <= cfg_data[30:0];
				kfsn_pkg::REG_QUAT:   quat_q  <= cfg_data[0];
				kfsn_pkg::REG_ORDER:  order_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	kfsn_ctrl #(.MAX_CHANNELS(MAX_CHANNELS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.channel(channel), .last_channel(last_channel), .cfg_mode(mode_q),
		.cfg_quat(quat_q), .kf_first(kf_first), .kf_last(kf_last), .sts(sts), .cmd(cmd)
	);

	kfsn_datapath #(.MAX_KEYFRAMES(MAX_KEYFRAMES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .cfg_mode(mode_q),
		.cfg_scale(scale_q), .cfg_quat(quat_q), .cfg_order(order_q),
		.key_time(key_time), .channel(channel), .value(value),
		.left_tangent(left_tangent), .right_tangent(right_tangent),
		.last_keyframe(last_keyframe), .kf_first(kf_first), .kf_last(kf_last),
		.out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
		.node_index(node_index), .node_time(node_time), .node_value(node_value),
		.node_slope(node_slope), .overflow(overflow), .last(last)
	);

	// a stalled result must not be overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.emit) else $error("result overwritten");
	// no item is taken while a keyframe is being worked on
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> in_stall) else $error("item taken mid keyframe");
	// divider is never restarted while running
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy) else $error("divider restarted");
endmodule

// ===== src/kfsn_div.sv =====
`timescale 1ns / 1ps
// Signed restoring divider, one quotient bit per cycle, truncating,
// 32-bit saturated quotient. A zero or negative divisor gives zero.
module kfsn_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [32:0] den,
	output logic               busy,
	output logic signed [31:0] quo
);
	logic [63:0] rem_q;
	logic [63:0] q_q;
	logic [31:0] d_q;
	logic        neg_q;
	logic        zero_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial;
	logic [63:0] shifted;
	logic signed [64:0] sq;

	assign shifted = {rem_q[62:0], q_q[63]};
	assign trial   = {1'b0, shifted} - {33'd0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= (den > 33'sd0);
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			q_q    <= num[63] ? 64'(-num) : num;
			d_q    <= den[31:0];
			neg_q  <= num[63];
			zero_q <= !(den > 33'sd0);
		end else if (busy) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	always_comb begin
		sq = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
		quo = zero_q ? 32'sd0 : kfsn_pkg::sat32(sq[63:0]);
		if (!zero_q && q_q[63] && !neg_q) quo = 32'sh7fffffff;
		if (!zero_q && q_q[63] && neg_q) quo = 32'sh80000000;
	end
endmodule

// ===== src/kfsn_datapath.sv =====
`timescale 1ns / 1ps
module kfsn_datapath #(
	parameter int MAX_KEYFRAMES = kfsn_pkg::MAX_KEYFRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kfsn_pkg::kfsn_cmd_t cmd,
	output kfsn_pkg::kfsn_sts_t sts,
	input  logic [1:0]         cfg_mode,
	input  logic [30:0]        cfg_scale,
	input  logic               cfg_quat,
	input  logic               cfg_order,
	input  logic signed [31:0] key_time,
	input  logic [1:0]         channel,
	input  logic signed [31:0] value,
	input  logic signed [31:0] left_tangent,
	input  logic signed [31:0] right_tangent,
	input  logic               last_keyframe,
	output logic               kf_first,
	output logic               kf_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         out_channel,
	output logic [12:0]        node_index,
	output logic signed [31:0] node_time,
	output logic signed [31:0] node_value,
	output logic signed [31:0] node_slope,
	output logic               overflow,
	output logic               last
);
	localparam int KW = $clog2(MAX_KEYFRAMES + 1);

	logic signed [31:0] cur_v_q [4];
	logic signed [31:0] cur_l_q [4];
	logic signed [31:0] cur_r_q [4];
	logic signed [31:0] prev_v_q [4];
	logic signed [31:0] prev_t_q;
	logic [KW-1:0]      kcount_q;
	logic signed [31:0] time_q;
	logic               lastkf_q;
	logic signed [65:0] dot_q;
	logic [1:0]         dot_i_q;
	logic signed [63:0] prod_s1;
	logic               prod_v_s1;
	logic signed [63:0] div_num;
	logic signed [32:0] div_den;
	logic               div_busy;
	logic signed [31:0] div_quo;
	logic signed [63:0] tprod;
	logic signed [32:0] dt;
	logic signed [31:0] v_c, slope;
	logic [12:0]        idx;

	assign kf_first = (kcount_q == '0);
	assign kf_last  = lastkf_q;
	assign tprod    = key_time * $signed({1'b0, cfg_scale});
	assign dt       = $signed({time_q[31], time_q}) - $signed({prev_t_q[31], prev_t_q});

	// divider operands
	always_comb begin
		unique case (cmd.div_sel)
			kfsn_pkg::DIV_LEFT: begin
				div_num = $signed({{16{cur_l_q[cmd.chan][31]}}, cur_l_q[cmd.chan], 16'd0});
				div_den = $signed({2'b0, cfg_scale});
			end
			kfsn_pkg::DIV_RIGHT: begin
				div_num = $signed({{16{cur_r_q[cmd.chan][31]}}, cur_r_q[cmd.chan], 16'd0});
				div_den = $signed({2'b0, cfg_scale});
			end
			default: begin
				div_num = ($signed({{32{cur_v_q[cmd.chan][31]}}, cur_v_q[cmd.chan]})
					- $signed({{32{prev_v_q[cmd.chan][31]}}, prev_v_q[cmd.chan]})) <<< 16;
				div_den = dt;
			end
		endcase
	end

	kfsn_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(div_num), .den(div_den), .busy(div_busy), .quo(div_quo)
	);

	assign sts.div_busy = div_busy;
	assign sts.out_full = out_valid && out_stall;

	// node fields
	always_comb begin
		v_c   = cur_v_q[cmd.chan];
		slope = 32'sd0;
		if (cfg_mode != kfsn_pkg::MODE_STEP && !(cfg_mode == kfsn_pkg::MODE_LINEAR
			&& (kf_first && cmd.kind == kfsn_pkg::NODE_LEFT || cmd.kind == kfsn_pkg::NODE_RIGHT)))
			slope = div_quo;
		if (cmd.kind == kfsn_pkg::NODE_HELD) idx = 13'(2 * kcount_q - 1);
		else if (cmd.kind == kfsn_pkg::NODE_LEFT) idx = 13'(2 * kcount_q);
		else idx = 13'(2 * kcount_q + 1);
	end

	// element store and keyframe state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) prev_v_q[i] <= '0;
			prev_t_q  <= '0;
			kcount_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.kf_end) begin
				for (int i = 0; i < 4; i++) prev_v_q[i] <= cur_v_q[i];
				prev_t_q <= time_q;
				if (lastkf_q) kcount_q <= '0;
				else if (kcount_q < KW'(MAX_KEYFRAMES)) kcount_q <= kcount_q + 1'b1;
			end
			if (cmd.emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			cur_v_q[channel] <= value;
			cur_l_q[channel] <= left_tangent;
			cur_r_q[channel] <= right_tangent;
		end
		if (cmd.kf_start) begin
			time_q   <= kfsn_pkg::sat32(tprod >>> 16);
			lastkf_q <= last_keyframe;
			dot_q    <= '0;
			dot_i_q  <= '0;
		end
		// dot product: one registered multiply, then accumulate
		prod_v_s1 <= cmd.dot_step;
		prod_s1   <= cur_v_q[dot_i_q] * prev_v_q[dot_i_q];
		if (cmd.dot_step) dot_i_q <= dot_i_q + 2'd1;
		if (prod_v_s1) dot_q <= dot_q + 66'(prod_s1);
		if (cmd.flip && dot_q < 0)
			for (int i = 0; i < 4; i++)
				cur_v_q[i] <= (cur_v_q[i] == 32'sh80000000) ? 32'sh7fffffff : -cur_v_q[i];
		if (cmd.emit) begin
			out_channel <= (cfg_quat && cfg_order) ? cmd.chan + 2'd1 : cmd.chan;
			node_index  <= idx;
			overflow    <= (kcount_q >= KW'(MAX_KEYFRAMES));
			last        <= cmd.last_node;
			node_slope  <= slope;
			if (cmd.kind == kfsn_pkg::NODE_HELD) begin
				node_time  <= prev_t_q;
				node_value <= prev_v_q[cmd.chan];
			end else begin
				node_time  <= time_q;
				node_value <= (cfg_mode == kfsn_pkg::MODE_STEP && cmd.kind == kfsn_pkg::NODE_LEFT
					&& !kf_first) ? prev_v_q[cmd.chan] : v_c;
			end
		end
	end
endmodule

// ===== src/kfsn_ctrl.sv =====
`timescale 1ns / 1ps
module kfsn_ctrl #(
	parameter int MAX_CHANNELS = kfsn_pkg::MAX_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         channel,
	input  logic               last_channel,
	input  logic [1:0]         cfg_mode,
	input  logic               cfg_quat,
	input  logic               kf_first,
	input  logic               kf_last,
	input  kfsn_pkg::kfsn_sts_t sts,
	output kfsn_pkg::kfsn_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_TIME, S_DOT, S_DOTW, S_FLIP, S_CHAN, S_DIVW, S_EMIT, S_END
	} state_t;

	typedef kfsn_pkg::node_kind_t node_kind_t;

	state_t     state_q;
	logic [1:0] ch_q, nch_q, dcnt_q;
	node_kind_t kind_q;
	logic       lin, cub;
	logic       accept;

	assign lin      = (cfg_mode == kfsn_pkg::MODE_LINEAR);
	assign cub      = !lin && (cfg_mode != kfsn_pkg::MODE_STEP);
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// whether another node follows kind_q on this channel
	function automatic logic has_next(input node_kind_t k, input logic l, input logic lk);
		logic r;
		if (k == kfsn_pkg::NODE_HELD) r = 1'b1;
		else if (k == kfsn_pkg::NODE_LEFT) r = !l || lk;
		else r = 1'b0;
		return r;
	endfunction

	always_comb begin
		cmd = '0;
		cmd.store     = accept;
		cmd.kf_start  = accept && last_channel;
		cmd.chan      = ch_q;
		cmd.kind      = kind_q;
		cmd.dot_step  = (state_q == S_DOT);
		cmd.flip      = (state_q == S_FLIP);
		cmd.kf_end    = (state_q == S_END);
		cmd.div_sel   = lin ? kfsn_pkg::DIV_LINEAR
			: (kind_q == kfsn_pkg::NODE_RIGHT ? kfsn_pkg::DIV_RIGHT : kfsn_pkg::DIV_LEFT);
		cmd.div_start = (state_q == S_CHAN);
		cmd.emit      = (state_q == S_EMIT) && !sts.out_full;
		cmd.last_node = !has_next(kind_q, lin, kf_last) && (ch_q == nch_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q    <= '0;
			nch_q   <= '0;
			dcnt_q  <= '0;
			kind_q  <= kfsn_pkg::NODE_LEFT;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept && last_channel) begin
					state_q <= S_TIME;
					if (cfg_quat) nch_q <= 2'd3;
					else if (int'(channel) + 1 > MAX_CHANNELS) nch_q <= 2'(MAX_CHANNELS - 1);
					else nch_q <= channel;
				end
				S_TIME: begin
					ch_q   <= '0;
					dcnt_q <= '0;
					state_q <= (cfg_quat && lin && !kf_first) ? S_DOT : S_CHAN;
					kind_q <= (lin && !kf_first) ? kfsn_pkg::NODE_HELD : kfsn_pkg::NODE_LEFT;
				end
				S_DOT: begin
					dcnt_q <= dcnt_q + 2'd1;
					if (dcnt_q == 2'd3) state_q <= S_DOTW;
				end
				S_DOTW: state_q <= S_FLIP;
				S_FLIP: state_q <= S_CHAN;
				S_CHAN: state_q <= S_DIVW;
				S_DIVW: if (!sts.div_busy) state_q <= S_EMIT;
				S_EMIT: if (!sts.out_full) begin
					if (has_next(kind_q, lin, kf_last)) begin
						kind_q  <= (kind_q == kfsn_pkg::NODE_HELD) ? kfsn_pkg::NODE_LEFT
							: kfsn_pkg::NODE_RIGHT;
						state_q <= cub ? S_CHAN : S_EMIT;
					end else if (ch_q != nch_q) begin
						ch_q    <= ch_q + 2'd1;
						kind_q  <= (lin && !kf_first) ? kfsn_pkg::NODE_HELD : kfsn_pkg::NODE_LEFT;
						state_q <= S_CHAN;
					end else state_q <= S_END;
				end
				S_END: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	localparam int KF_CAP    = 4096;
	localparam int WD_LIMIT  = 20000;
	localparam int SETTLE    = 300;

	typedef struct {
		logic signed [31:0] key_time;
		logic [1:0]         chan;
		logic signed [31:0] value;
		logic signed [31:0] ltan;
		logic signed [31:0] rtan;
		logic               lc;
		logic               lk;
	} elem_t;

	typedef struct {
		logic [1:0]         chan;
		logic [12:0]        idx;
		logic signed [31:0] t;
		logic signed [31:0] v;
		logic signed [31:0] s;
		logic               ovf;
		logic               last;
	} node_t;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic signed [31:0] key_time, value, left_tangent, right_tangent;
	logic [1:0] channel;
	logic last_channel, last_keyframe;
	logic out_valid, out_stall;
	logic [1:0] out_channel;
	logic [12:0] node_index;
	logic signed [31:0] node_time, node_value, node_slope;
	logic overflow, last;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	keyframe_to_spline_nodes DUT (.*);

	// shadow of the block's registers and state
	logic [1:0]  sh_mode;
	logic [30:0] sh_scale;
	logic        sh_quat, sh_order;
	logic signed [31:0] cur_v[4], cur_l[4], cur_r[4], prev_v[4];
	logic signed [31:0] prev_t;
	int unsigned kf_count;

	elem_t pending[$];
	node_t nodes_due[$];
	int errors, n_items, n_nodes, n_cfg, n_kf, n_flip, idle_cycles;
	int in_gap, out_wait;
	logic no_idle;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [31:0] sat(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] rnd32();
		case ($urandom_range(0, 7))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	// work out the nodes caused by one accepted element
	function automatic void predict_nodes(input elem_t e);
		int unsigned n, k, mode, oc, li;
		logic ovf;
		logic signed [31:0] tm, v, s;
		longint dt, p;
		logic signed [65:0] acc;
		node_t nd[$];
		node_t x;
		cur_v[e.chan] = e.value;
		cur_l[e.chan] = e.ltan;
		cur_r[e.chan] = e.rtan;
		if (!e.lc) return;
		n = sh_quat ? 4 : e.chan + 1;
		k = kf_count;
		ovf = k >= KF_CAP;
		mode = (sh_mode == kfsn_pkg::MODE_CUBIC_ALT) ? kfsn_pkg::MODE_CUBIC : sh_mode;
		tm = sat((longint'(e.key_time) * longint'({33'd0, sh_scale})) >>> 16);
		n_kf++;
		// quaternion hemisphere check
		if (sh_quat && mode == kfsn_pkg::MODE_LINEAR && k > 0) begin
			acc = 0;
			for (int c = 0; c < 4; c++) begin
				p = longint'(cur_v[c]) * longint'(prev_v[c]);
				acc = acc + {{2{p[63]}}, p};
			end
			if (acc[65]) begin
				n_flip++;
				for (int c = 0; c < 4; c++) cur_v[c] = sat(-longint'(cur_v[c]));
			end
		end
		for (int c = 0; c < n; c++) begin
			oc = (sh_quat && sh_order) ? ((c + 1) & 3) : c;
			v = cur_v[c];
			li = 2 * k;
			x.chan = oc[1:0];
			x.ovf = ovf;
			x.last = 0;
			if (mode == kfsn_pkg::MODE_LINEAR) begin
				if (k > 0) begin
					dt = longint'(tm) - longint'(prev_t);
					s = 0;
					if (dt > 0) s = sat(((longint'(v) - longint'(prev_v[c])) * 65536) / dt);
					x.idx = 13'(li - 1); x.t = prev_t; x.v = prev_v[c]; x.s = s;
					nd.push_back(x);
					x.idx = 13'(li); x.t = tm; x.v = v; x.s = s;
					nd.push_back(x);
				end else begin
					x.idx = 13'(li); x.t = tm; x.v = v; x.s = 0;
					nd.push_back(x);
				end
				if (e.lk) begin
					x.idx = 13'(li + 1); x.t = tm; x.v = v; x.s = 0;
					nd.push_back(x);
				end
			end else if (mode == kfsn_pkg::MODE_STEP) begin
				x.idx = 13'(li); x.t = tm; x.v = (k > 0) ? prev_v[c] : v; x.s = 0;
				nd.push_back(x);
				x.idx = 13'(li + 1); x.v = v;
				nd.push_back(x);
			end else begin
				x.idx = 13'(li); x.t = tm; x.v = v;
				x.s = (sh_scale == 0) ? 0 :
					sat((longint'(cur_l[c]) * 65536) / longint'({33'd0, sh_scale}));
				nd.push_back(x);
				x.idx = 13'(li + 1);
				x.s = (sh_scale == 0) ? 0 :
					sat((longint'(cur_r[c]) * 65536) / longint'({33'd0, sh_scale}));
				nd.push_back(x);
			end
		end
		for (int c = 0; c < 4; c++) prev_v[c] = cur_v[c];
		prev_t = tm;
		if (e.lk) kf_count = 0;
		else if (kf_count < KF_CAP) kf_count++;
		if (nd.size() > 0) nd[nd.size() - 1].last = 1;
		foreach (nd[i]) nodes_due.push_back(nd[i]);
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				n_items++;
				predict_nodes('{key_time, channel, value, left_tangent, right_tangent,
					last_channel, last_keyframe});
			end
			if (in_gap > 0) begin
				in_valid <= 0;
				in_gap <= in_gap - 1;
			end else if (pending.size() > 0) begin
				elem_t e;
				e = pending.pop_front();
				key_time <= e.key_time;
				channel <= e.chan;
				value <= e.value;
				left_tangent <= e.ltan;
				right_tangent <= e.rtan;
				last_channel <= e.lc;
				last_keyframe <= e.lk;
				in_valid <= 1;
				in_gap <= no_idle ? 0 : $urandom_range(0, 4);
			end else begin
				in_valid <= 0;
			end
		end
	end

	function automatic void cmp(input string f, input longint ex, input longint ac);
		if (ex != ac) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $realtime, f, ex, ac);
		end
	endfunction

	// result monitor with random stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			out_wait <= 0;
		end else if (out_valid && !out_stall) begin
			int w;
			node_t x;
			n_nodes++;
			if (nodes_due.size() == 0) begin
				errors++;
				$display("%0t: node item with nothing expected, index %0d", $realtime,
					node_index);
			end else begin
				x = nodes_due.pop_front();
				cmp("out_channel", x.chan, out_channel);
				cmp("node_index", x.idx, node_index);
				cmp("node_time", x.t, node_time);
				cmp("node_value", x.v, node_value);
				cmp("node_slope", x.s, node_slope);
				cmp("overflow", x.ovf, overflow);
				cmp("last", x.last, last);
			end
			w = no_idle ? 0 : $urandom_range(0, 4);
			out_wait <= w;
			out_stall <= (w != 0);
		end else if (out_wait > 0) begin
			out_wait <= out_wait - 1;
			out_stall <= (out_wait > 1);
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WD_LIMIT) begin
				$display("watchdog expired with %0d nodes outstanding", nodes_due.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		n_cfg++;
		case (idx)
			kfsn_pkg::REG_INTERP: sh_mode = data[1:0];
			kfsn_pkg::REG_SCALE:  sh_scale = data[30:0];
			kfsn_pkg::REG_QUAT:   sh_quat = data[0];
			kfsn_pkg::REG_ORDER:  sh_order = data[0];
		endcase
	endtask

	// wait until all items are in and every node is out, then let the block settle
	task automatic drain();
		@(posedge clk);
		while (pending.size() > 0 || in_valid || nodes_due.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_all(input logic [1:0] m, input logic [30:0] sc, input logic q,
		input logic o);
		drain();
		write_reg(kfsn_pkg::REG_INTERP, {30'd0, m});
		write_reg(kfsn_pkg::REG_SCALE, {1'b0, sc});
		write_reg(kfsn_pkg::REG_QUAT, {31'd0, q});
		write_reg(kfsn_pkg::REG_ORDER, {31'd0, o});
	endtask

	// one keyframe: every channel written, the last element completes it
	task automatic push_keyframe(input int nch, input logic [31:0] t, input logic lk);
		elem_t e;
		for (int c = 0; c < nch; c++) begin
			e.chan = 2'(c);
			e.value = rnd32();
			e.ltan = rnd32();
			e.rtan = rnd32();
			e.lc = (c == nch - 1);
			e.key_time = e.lc ? t : $urandom;
			e.lk = e.lc ? lk : 1'($urandom_range(0, 1));
			if (!e.lc && $urandom_range(0, 7) == 0) begin
				// element rewritten before the keyframe completes
				pending.push_back(e);
				e.value = rnd32();
			end
			pending.push_back(e);
		end
	endtask

	task automatic push_track(input int nkeys, input int nch, input logic close);
		logic [31:0] t;
		t = $urandom_range(0, 1000);
		for (int i = 0; i < nkeys; i++) begin
			case ($urandom_range(0, 9))
				0: t = t - $urandom_range(0, 100);
				1: t = rnd32();
				default: t = t + $urandom_range(1, 1 << 20);
			endcase
			push_keyframe(nch, t, close && (i == nkeys - 1));
		end
	endtask

	initial begin
		logic [30:0] sc;
		logic q;
		arst_n = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; out_stall = 0;
		key_time = 0; channel = 0; value = 0; left_tangent = 0; right_tangent = 0;
		last_channel = 0; last_keyframe = 0;
		no_idle = 0;
		errors = 0; n_items = 0; n_nodes = 0; n_cfg = 0; n_kf = 0; n_flip = 0;
		idle_cycles = 0;
		sh_mode = kfsn_pkg::MODE_LINEAR; sh_scale = 31'd65536; sh_quat = 0; sh_order = 0;
		for (int c = 0; c < 4; c++) begin
			cur_v[c] = 0; cur_l[c] = 0; cur_r[c] = 0; prev_v[c] = 0;
		end
		prev_t = 0; kf_count = 0;
		repeat (9) @(posedge clk);
		arst_n = 1;

		// directed: reset settings, then extremes of each mode
		push_track(2, 2, 1);
		set_all(kfsn_pkg::MODE_STEP, 31'd1, 0, 0);
		push_track(2, 1, 1);
		set_all(kfsn_pkg::MODE_CUBIC, 31'd1, 0, 0);
		push_keyframe(4, 32'h7fffffff, 1);
		set_all(kfsn_pkg::MODE_CUBIC_ALT, 31'h7fffffff, 0, 0);
		push_keyframe(3, 32'h80000000, 1);
		set_all(kfsn_pkg::MODE_LINEAR, 31'd65536, 1, 1);
		push_track(3, 4, 1);

		// random phases
		while (n_items + pending.size() < 240) begin
			case ($urandom_range(0, 3))
				0: sc = 31'd1;
				1: sc = 31'h7fffffff;
				2: sc = 31'd65536;
				default: sc = 31'($urandom_range(1, 32'h7fffffff));
			endcase
			q = ($urandom_range(0, 2) == 0);
			set_all(2'($urandom_range(0, 3)), sc, q, 1'($urandom_range(0, 1)));
			no_idle = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3))
				push_track($urandom_range(1, 5), q ? 4 : $urandom_range(1, 4),
					$urandom_range(0, 3) != 0);
		end
		drain();

		$display("%0d elements, %0d keyframes, %0d nodes, %0d register writes, %0d flips",
			n_items, n_kf, n_nodes, n_cfg, n_flip);
		$display("linear, step and cubic modes, quaternion flips and order, open tracks run");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/kfsn_pkg.sv
src/kfsn_div.sv
src/kfsn_datapath.sv
src/kfsn_ctrl.sv
src/keyframe_to_spline_nodes.sv
tb/tb_top.sv
